/* hdl/cke_pkg.sv */
// ----------------------------------------------------------------------------
// cke_pkg
// Shared types and constants for the color-key run extractor: frame limits,
// configuration register map and the result record.
// ----------------------------------------------------------------------------
package cke_pkg;

  // Frame limits; the port widths below are sized for these
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int BATCH_SIZE = 2000;

  localparam int COL_W  = $clog2(MAX_WIDTH);   // column counter
  localparam int ROW_W  = $clog2(MAX_HEIGHT);  // row counter
  localparam int EDGE_W = 13;                  // box edges, exclusive right
  localparam int SIZE_W = 13;                  // image size registers
  localparam int KEY_W  = 24;
  localparam int CHAN_W = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_COLOR        = 2'd0,
    REG_KEEP_NONMATCHING = 2'd1,
    REG_IMAGE_WIDTH      = 2'd2,
    REG_IMAGE_HEIGHT     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key_color;
    logic              keep_nonmatching;
    logic [SIZE_W-1:0] image_width;
    logic [SIZE_W-1:0] image_height;
  } cfg_t;

  // One result record
  typedef struct packed {
    logic              rect_valid;
    logic [COL_W-1:0]  rect_left;
    logic [EDGE_W-1:0] rect_right;
    logic [ROW_W-1:0]  rect_row;
    logic [EDGE_W-1:0] bound_left;
    logic [EDGE_W-1:0] bound_top;
    logic [EDGE_W-1:0] bound_right;
    logic [EDGE_W-1:0] bound_bottom;
    logic              batch_end;
    logic              frame_end;
  } result_t;

endpackage

/* hdl/cke_run_core.sv */
// ----------------------------------------------------------------------------
// cke_run_core
// Per-pixel key compare, run tracking, raster counters and batch bounding box.
// Result for the pixel on its inputs is combinational; state moves on step.
// ----------------------------------------------------------------------------
module cke_run_core #(
  parameter int BATCH_SIZE = cke_pkg::BATCH_SIZE
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [cke_pkg::CHAN_W-1:0]   pixel_red,
  input  logic [cke_pkg::CHAN_W-1:0]   pixel_green,
  input  logic [cke_pkg::CHAN_W-1:0]   pixel_blue,
  input  cke_pkg::cfg_t                cfg,
  output logic                         emit,
  output cke_pkg::result_t             res
);

  localparam int CNT_W  = $clog2(BATCH_SIZE + 1);
  localparam int COL_W  = cke_pkg::COL_W;
  localparam int ROW_W  = cke_pkg::ROW_W;
  localparam int EDGE_W = cke_pkg::EDGE_W;
  localparam int SIZE_W = cke_pkg::SIZE_W;
  localparam logic [EDGE_W-1:0] BOX_L_RST = EDGE_W'(cke_pkg::MAX_WIDTH);
  localparam logic [EDGE_W-1:0] BOX_T_RST = EDGE_W'(cke_pkg::MAX_HEIGHT);

  // State
  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;
  logic              run_open;
  logic [COL_W-1:0]  run_start;
  logic [CNT_W-1:0]  batch_rects;
  logic [EDGE_W-1:0] box_left, box_top, box_right, box_bottom;

  // Per-pixel terms
  logic              match, kept;
  logic [SIZE_W-1:0] width_eff, height_eff;
  logic [EDGE_W-1:0] col_ext, row_ext, col_inc, row_inc;
  logic              last_col, last_row, frame_end;
  logic              close_miss, close_end, have_rect, batch_end;
  logic [COL_W-1:0]  start_now, rect_l;
  logic [EDGE_W-1:0] rect_l_ext, rect_r;
  logic [CNT_W-1:0]  rects_inc, rects_now;
  logic [EDGE_W-1:0] box_l_now, box_t_now, box_r_now, box_b_now;

  // Effective frame size: zero reads as one, oversize saturates
  always_comb begin
    if (cfg.image_width == '0) begin
      width_eff = SIZE_W'(1);
    end else if (cfg.image_width > SIZE_W'(cke_pkg::MAX_WIDTH)) begin
      width_eff = SIZE_W'(cke_pkg::MAX_WIDTH);
    end else begin
      width_eff = cfg.image_width;
    end
    if (cfg.image_height == '0) begin
      height_eff = SIZE_W'(1);
    end else if (cfg.image_height > SIZE_W'(cke_pkg::MAX_HEIGHT)) begin
      height_eff = SIZE_W'(cke_pkg::MAX_HEIGHT);
    end else begin
      height_eff = cfg.image_height;
    end
  end

  // Key compare and raster position
  assign match     = ({pixel_blue, pixel_green, pixel_red} == cfg.key_color);
  assign kept      = cfg.keep_nonmatching ? !match : match;
  assign col_ext   = EDGE_W'(column_count);
  assign row_ext   = EDGE_W'(row_count);
  assign col_inc   = col_ext + EDGE_W'(1);
  assign row_inc   = row_ext + EDGE_W'(1);
  assign last_col  = (col_inc >= width_eff);
  assign last_row  = (row_inc >= height_eff);
  assign frame_end = last_col && last_row;

  // Run close: on a dropped pixel, or at the row end while kept
  assign close_miss = run_open && !kept;
  assign start_now  = (kept && !run_open) ? column_count : run_start;
  assign close_end  = last_col && kept;
  assign have_rect  = close_miss || close_end;
  assign rect_l     = close_end ? start_now : run_start;
  assign rect_l_ext = EDGE_W'(rect_l);
  assign rect_r     = close_end ? col_inc : col_ext;

  // Batch box including this rectangle
  assign rects_inc = CNT_W'(batch_rects + CNT_W'(1));
  assign rects_now = have_rect ? rects_inc : batch_rects;
  assign box_l_now = (have_rect && rect_l_ext < box_left) ? rect_l_ext : box_left;
  assign box_t_now = (have_rect && row_ext < box_top) ? row_ext : box_top;
  assign box_r_now = (have_rect && rect_r > box_right) ? rect_r : box_right;
  assign box_b_now = (have_rect && row_inc > box_bottom) ? row_inc : box_bottom;
  assign batch_end = (have_rect && rects_inc >= CNT_W'(BATCH_SIZE)) ||
                     (frame_end && rects_now != '0);

  // Result record
  assign emit = have_rect || frame_end;
  always_comb begin
    res.rect_valid   = have_rect;
    res.rect_left    = have_rect ? rect_l : '0;
    res.rect_right   = have_rect ? rect_r : '0;
    res.rect_row     = have_rect ? row_count : '0;
    res.bound_left   = box_l_now;
    res.bound_top    = box_t_now;
    res.bound_right  = box_r_now;
    res.bound_bottom = box_b_now;
    res.batch_end    = batch_end;
    res.frame_end    = frame_end;
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      run_open     <= 1'b0;
      run_start    <= '0;
      batch_rects  <= '0;
      box_left     <= BOX_L_RST;
      box_top      <= BOX_T_RST;
      box_right    <= '0;
      box_bottom   <= '0;
    end else if (step) begin
      run_open  <= kept && !last_col;
      run_start <= start_now;
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : ROW_W'(row_inc);
      end else begin
        column_count <= COL_W'(col_inc);
      end
      if (batch_end) begin
        batch_rects <= '0;
        box_left    <= BOX_L_RST;
        box_top     <= BOX_T_RST;
        box_right   <= '0;
        box_bottom  <= '0;
      end else begin
        batch_rects <= rects_now;
        box_left    <= box_l_now;
        box_top     <= box_t_now;
        box_right   <= box_r_now;
        box_bottom  <= box_b_now;
      end
    end
  end

  // Checks
  a_rect_order: assert property (@(posedge clk) disable iff (rst)
    step && have_rect |-> rect_l_ext < rect_r)
    else $error("run rectangle with left not below right");

  a_run_start: assert property (@(posedge clk) disable iff (rst)
    run_open |-> run_start < column_count)
    else $error("open run starts at or after current column");

  a_batch_cnt: assert property (@(posedge clk) disable iff (rst)
    batch_rects < CNT_W'(BATCH_SIZE))
    else $error("batch count reached batch size without reset");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    step && frame_end |=> column_count == '0 && row_count == '0 && !run_open)
    else $error("counters not cleared after frame end");

endmodule

/* hdl/color_key_run_extractor.sv */
// ----------------------------------------------------------------------------
// color_key_run_extractor
// Color-key run-length extractor: one-row rectangles of kept pixels plus the
// running bounding box of each batch of rectangles.
// ----------------------------------------------------------------------------
// A result passes the input register, then the result register, after its
//   pixel request is accepted.
// Throughput: one pixel per cycle; the key compare and box update fit one stage.
// A waiting result stalls the input only while the result register is full.
// Reset (rst, synchronous): empties both stages, loads register defaults,
//   clears counters and the open run, and resets the batch box.
module color_key_run_extractor #(
  parameter int BATCH_SIZE = cke_pkg::BATCH_SIZE
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_write,
  input  logic [cke_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cke_pkg::CFG_DATA_W-1:0]  cfg_data,
  // pixel channel
  input  logic                            pixel_valid,
  output logic                            pixel_ready,
  input  logic [cke_pkg::CHAN_W-1:0]      pixel_red,
  input  logic [cke_pkg::CHAN_W-1:0]      pixel_green,
  input  logic [cke_pkg::CHAN_W-1:0]      pixel_blue,
  // result channel
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic                            rect_valid,
  output logic [cke_pkg::COL_W-1:0]       rect_left,
  output logic [cke_pkg::EDGE_W-1:0]      rect_right,
  output logic [cke_pkg::ROW_W-1:0]       rect_row,
  output logic [cke_pkg::EDGE_W-1:0]      bound_left,
  output logic [cke_pkg::EDGE_W-1:0]      bound_top,
  output logic [cke_pkg::EDGE_W-1:0]      bound_right,
  output logic [cke_pkg::EDGE_W-1:0]      bound_bottom,
  output logic                            batch_end,
  output logic                            frame_end
);

  cke_pkg::cfg_t    cfg;
  logic                       px_valid;
  logic [cke_pkg::CHAN_W-1:0] px_red, px_green, px_blue;
  logic                       advance, step, emit;
  cke_pkg::result_t           res_next, res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_color        <= '0;
      cfg.keep_nonmatching <= 1'b1;
      cfg.image_width      <= cke_pkg::SIZE_W'(cke_pkg::MAX_WIDTH);
      cfg.image_height     <= cke_pkg::SIZE_W'(cke_pkg::MAX_HEIGHT);
    end else if (cfg_write) begin
      case (cke_pkg::cfg_reg_t'(cfg_index))
        cke_pkg::REG_KEY_COLOR: begin
          cfg.key_color <= cfg_data[cke_pkg::KEY_W-1:0];
        end
        cke_pkg::REG_KEEP_NONMATCHING: begin
          cfg.keep_nonmatching <= cfg_data[0];
        end
        cke_pkg::REG_IMAGE_WIDTH: begin
          cfg.image_width <= cfg_data[cke_pkg::SIZE_W-1:0];
        end
        cke_pkg::REG_IMAGE_HEIGHT: begin
          cfg.image_height <= cfg_data[cke_pkg::SIZE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Handshake: the pixel stage moves whenever the result register can load
  assign advance     = !result_valid || result_ready;
  assign step        = px_valid && advance;
  assign pixel_ready = !px_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      px_valid <= 1'b0;
    end else if (pixel_ready) begin
      px_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_valid && pixel_ready) begin
      px_red   <= pixel_red;
      px_green <= pixel_green;
      px_blue  <= pixel_blue;
    end
  end

  // Run tracking and batch box
  cke_run_core #(
    .BATCH_SIZE (BATCH_SIZE)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .pixel_red   (px_red),
    .pixel_green (px_green),
    .pixel_blue  (px_blue),
    .cfg         (cfg),
    .emit        (emit),
    .res         (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      res <= res_next;
    end
  end

  assign rect_valid   = res.rect_valid;
  assign rect_left    = res.rect_left;
  assign rect_right   = res.rect_right;
  assign rect_row     = res.rect_row;
  assign bound_left   = res.bound_left;
  assign bound_top    = res.bound_top;
  assign bound_right  = res.bound_right;
  assign bound_bottom = res.bound_bottom;
  assign batch_end    = res.batch_end;
  assign frame_end    = res.frame_end;

endmodule

/* test/color_key_run_extractor_tb.sv */
// ----------------------------------------------------------------------------
// color_key_run_extractor_tb
// Self-checking bench for the color-key run extractor. Pixels are streamed in
// raster order under several key, mode and frame-size settings. A local model
// of the run and bounding-box logic predicts every result, and each accepted
// result is compared field by field in arrival order. Both channels idle and
// stall at random, and one long result hold-off backs up the pipeline.
// ----------------------------------------------------------------------------
module color_key_run_extractor_tb;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_write = 1'b0;
  logic [cke_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [cke_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           pixel_valid = 1'b0;
  logic                           pixel_ready;
  logic [cke_pkg::CHAN_W-1:0]     pixel_red = '0;
  logic [cke_pkg::CHAN_W-1:0]     pixel_green = '0;
  logic [cke_pkg::CHAN_W-1:0]     pixel_blue = '0;
  logic                           result_valid;
  logic                           result_ready = 1'b0;
  logic                           rect_valid;
  logic [cke_pkg::COL_W-1:0]      rect_left;
  logic [cke_pkg::EDGE_W-1:0]     rect_right;
  logic [cke_pkg::ROW_W-1:0]      rect_row;
  logic [cke_pkg::EDGE_W-1:0]     bound_left;
  logic [cke_pkg::EDGE_W-1:0]     bound_top;
  logic [cke_pkg::EDGE_W-1:0]     bound_right;
  logic [cke_pkg::EDGE_W-1:0]     bound_bottom;
  logic                           batch_end;
  logic                           frame_end;

  color_key_run_extractor #(
    .BATCH_SIZE(cke_pkg::BATCH_SIZE)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .pixel_red(pixel_red),
    .pixel_green(pixel_green),
    .pixel_blue(pixel_blue),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .rect_valid(rect_valid),
    .rect_left(rect_left),
    .rect_right(rect_right),
    .rect_row(rect_row),
    .bound_left(bound_left),
    .bound_top(bound_top),
    .bound_right(bound_right),
    .bound_bottom(bound_bottom),
    .batch_end(batch_end),
    .frame_end(frame_end)
  );

  // Clock: period 20
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the configuration registers
  logic [cke_pkg::KEY_W-1:0]  key_reg = '0;
  logic                       keep_reg = 1'b1;
  logic [cke_pkg::SIZE_W-1:0] width_reg = cke_pkg::SIZE_W'(cke_pkg::MAX_WIDTH);
  logic [cke_pkg::SIZE_W-1:0] height_reg = cke_pkg::SIZE_W'(cke_pkg::MAX_HEIGHT);

  // Model state: raster position, open run, batch box
  int col_pos = 0;
  int row_pos = 0;
  bit run_on = 1'b0;
  int run_from = 0;
  int rects_in_batch = 0;
  int box_l = cke_pkg::MAX_WIDTH;
  int box_t = cke_pkg::MAX_HEIGHT;
  int box_r = 0;
  int box_b = 0;

  cke_pkg::result_t predicted_runs[$];
  int               mismatch_count = 0;
  bit               idling_on = 1'b1;
  int               hold_left = 0;

  // Close and open runs for one pixel; returns 1 when the pixel yields a result
  function automatic bit extract_run(input logic [cke_pkg::KEY_W-1:0] px,
                                     output cke_pkg::result_t res);
    int w, h, col, row, left, right;
    bit kept, last_col, last_row, at_frame_end, got_rect, full;
    w = (width_reg == 0) ? 1 :
        ((int'(width_reg) > cke_pkg::MAX_WIDTH) ? cke_pkg::MAX_WIDTH : int'(width_reg));
    h = (height_reg == 0) ? 1 :
        ((int'(height_reg) > cke_pkg::MAX_HEIGHT) ? cke_pkg::MAX_HEIGHT : int'(height_reg));
    col = col_pos;
    row = row_pos;
    kept = keep_reg ? (px != key_reg) : (px == key_reg);
    last_col = (col + 1 >= w);
    last_row = (row + 1 >= h);
    at_frame_end = last_col && last_row;
    got_rect = 1'b0;
    full = 1'b0;
    left = 0;
    right = 0;

    if (run_on && !kept) begin
      got_rect = 1'b1;
      left = run_from;
      right = col;
      run_on = 1'b0;
    end else if (kept && !run_on) begin
      run_from = col;
      run_on = 1'b1;
    end
    // run still open at the row end closes on the last column
    if (last_col && run_on) begin
      got_rect = 1'b1;
      left = run_from;
      right = col + 1;
      run_on = 1'b0;
    end

    if (got_rect) begin
      if (left < box_l) box_l = left;
      if (row < box_t) box_t = row;
      if (right > box_r) box_r = right;
      if (row + 1 > box_b) box_b = row + 1;
      rects_in_batch++;
      if (rects_in_batch >= cke_pkg::BATCH_SIZE) full = 1'b1;
    end
    if (at_frame_end && rects_in_batch > 0) full = 1'b1;

    res.rect_valid   = got_rect;
    res.rect_left    = got_rect ? cke_pkg::COL_W'(left) : '0;
    res.rect_right   = got_rect ? cke_pkg::EDGE_W'(right) : '0;
    res.rect_row     = got_rect ? cke_pkg::ROW_W'(row) : '0;
    res.bound_left   = cke_pkg::EDGE_W'(box_l);
    res.bound_top    = cke_pkg::EDGE_W'(box_t);
    res.bound_right  = cke_pkg::EDGE_W'(box_r);
    res.bound_bottom = cke_pkg::EDGE_W'(box_b);
    res.batch_end    = full;
    res.frame_end    = at_frame_end;

    if (full) begin
      box_l = cke_pkg::MAX_WIDTH;
      box_t = cke_pkg::MAX_HEIGHT;
      box_r = 0;
      box_b = 0;
      rects_in_batch = 0;
    end

    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
    end
    return got_rect || at_frame_end;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input int unsigned got, input int unsigned want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", what, got, want));
  endtask

  // Predict on each accepted pixel, compare each accepted result
  always @(posedge clk) begin : check_results
    cke_pkg::result_t want;
    cke_pkg::result_t got;
    if (!rst) begin
      if (pixel_valid && pixel_ready) begin
        if (extract_run({pixel_blue, pixel_green, pixel_red}, want))
          predicted_runs.push_back(want);
      end
      if (result_valid && result_ready) begin
        got.rect_valid   = rect_valid;
        got.rect_left    = rect_left;
        got.rect_right   = rect_right;
        got.rect_row     = rect_row;
        got.bound_left   = bound_left;
        got.bound_top    = bound_top;
        got.bound_right  = bound_right;
        got.bound_bottom = bound_bottom;
        got.batch_end    = batch_end;
        got.frame_end    = frame_end;
        if (predicted_runs.size() == 0) begin
          report_mismatch("result request with no expected result pending");
        end else begin
          want = predicted_runs.pop_front();
          check_field("rect_valid", got.rect_valid, want.rect_valid);
          check_field("rect_left", got.rect_left, want.rect_left);
          check_field("rect_right", got.rect_right, want.rect_right);
          check_field("rect_row", got.rect_row, want.rect_row);
          check_field("bound_left", got.bound_left, want.bound_left);
          check_field("bound_top", got.bound_top, want.bound_top);
          check_field("bound_right", got.bound_right, want.bound_right);
          check_field("bound_bottom", got.bound_bottom, want.bound_bottom);
          check_field("batch_end", got.batch_end, want.batch_end);
          check_field("frame_end", got.frame_end, want.frame_end);
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= !(idling_on && $urandom_range(0, 99) < 6);
    end
  end

  // One pixel request; valid stays up until accepted
  task automatic send_pixel(input logic [cke_pkg::KEY_W-1:0] px);
    while (idling_on && $urandom_range(0, 99) < 6) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_red   <= px[7:0];
    pixel_green <= px[15:8];
    pixel_blue  <= px[23:16];
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
  endtask

  // Drain: wait for all expected results, then cover the pipeline depth
  task automatic wait_idle();
    int waited;
    waited = 0;
    pixel_valid <= 1'b0;
    while (predicted_runs.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Write all four registers; junk sets unused upper data bits
  task automatic configure(input logic [cke_pkg::KEY_W-1:0] key, input bit keep,
                           input logic [cke_pkg::SIZE_W-1:0] w,
                           input logic [cke_pkg::SIZE_W-1:0] h,
                           input bit junk);
    cke_pkg::cfg_reg_t              idx;
    logic [cke_pkg::CFG_DATA_W-1:0] data;
    logic [cke_pkg::CFG_DATA_W-1:0] noise;
    for (int i = 0; i < 4; i++) begin
      idx = cke_pkg::cfg_reg_t'(i);
      noise = junk ? cke_pkg::CFG_DATA_W'($urandom) : '0;
      case (idx)
        cke_pkg::REG_KEY_COLOR:        data = key;
        cke_pkg::REG_KEEP_NONMATCHING: data = {noise[cke_pkg::CFG_DATA_W-1:1], keep};
        cke_pkg::REG_IMAGE_WIDTH:      data = {noise[cke_pkg::CFG_DATA_W-1:cke_pkg::SIZE_W], w};
        default:                       data = {noise[cke_pkg::CFG_DATA_W-1:cke_pkg::SIZE_W], h};
      endcase
      cfg_write <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= data;
      @(posedge clk);
      case (idx)
        cke_pkg::REG_KEY_COLOR:        key_reg = data[cke_pkg::KEY_W-1:0];
        cke_pkg::REG_KEEP_NONMATCHING: keep_reg = data[0];
        cke_pkg::REG_IMAGE_WIDTH:      width_reg = data[cke_pkg::SIZE_W-1:0];
        default:                       height_reg = data[cke_pkg::SIZE_W-1:0];
      endcase
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Pixel colors: exact key, key with one bit off, or anything
  function automatic logic [cke_pkg::KEY_W-1:0] pick_color(input int key_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < key_pct) return key_reg;
    if (roll < key_pct + 15)
      return key_reg ^ (cke_pkg::KEY_W'(1) << $urandom_range(0, cke_pkg::KEY_W - 1));
    return cke_pkg::KEY_W'($urandom);
  endfunction

  function automatic logic [cke_pkg::KEY_W-1:0] off_key();
    logic [cke_pkg::KEY_W-1:0] c;
    c = cke_pkg::KEY_W'($urandom);
    if (c == key_reg) c = ~c;
    return c;
  endfunction

  // Reset config (key 0, keep non-matching, 4096 wide): two short runs
  task automatic test_reset_defaults();
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h0000FF);
    send_pixel(24'h000000);
    send_pixel(24'h00FF00);
    send_pixel(24'hFF0000);
    send_pixel(24'h000000);
    wait_idle();
  endtask

  // Shrink the frame mid-row: column already past the new width ends the row
  task automatic test_size_change();
    configure(24'h000000, 1'b0, 13'd3, 13'd2, 1'b0);
    send_pixel(24'h000000);
    send_pixel(24'h000000);
    send_pixel(24'h000001);
    send_pixel(24'h000000);
    wait_idle();
  endtask

  // Frame with nothing kept: frame-end result only, box still at reset
  task automatic test_empty_frame();
    configure(24'hABCDEF, 1'b1, 13'd2, 13'd2, 1'b0);
    repeat (4) send_pixel(24'hABCDEF);
    wait_idle();
  endtask

  // Zero sizes act as 1x1: every pixel is a whole frame
  task automatic test_zero_size();
    configure(24'hFFFFFF, 1'b1, 13'd0, 13'd0, 1'b0);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    send_pixel(24'h7F80FF);
    wait_idle();
  endtask

  // Runs reaching the right edge close there
  task automatic test_row_end_runs();
    configure(24'h123456, 1'b1, 13'd5, 13'd2, 1'b0);
    repeat (5) send_pixel(off_key());
    send_pixel(off_key());
    send_pixel(24'h123456);
    repeat (3) send_pixel(off_key());
    wait_idle();
  endtask

  // Random settings and small frames, one phase after another
  task automatic test_random_frames();
    int sent, phase, len, key_pct, roll;
    logic [cke_pkg::SIZE_W-1:0] w, h;
    sent = 0;
    phase = 0;
    while (sent < 850) begin
      roll = $urandom_range(0, 9);
      w = (roll == 0) ? '0 : (roll == 1) ? cke_pkg::SIZE_W'($urandom_range(13, 64))
                                         : cke_pkg::SIZE_W'($urandom_range(1, 12));
      roll = $urandom_range(0, 9);
      h = (roll == 0) ? '0 : cke_pkg::SIZE_W'($urandom_range(1, 6));
      configure(cke_pkg::KEY_W'($urandom), 1'($urandom), w, h, 1'($urandom));
      // one long phase runs with no idling on either side
      idling_on = (phase != 1);
      len = (phase == 1) ? 250 : $urandom_range(40, 200);
      key_pct = $urandom_range(20, 70);
      repeat (len) send_pixel(pick_color(key_pct));
      sent += len;
      phase++;
      wait_idle();
      idling_on = 1'b1;
    end
  endtask

  // One pixel per row, height saturated to the maximum: a result per kept pixel
  task automatic test_tall_column();
    configure(cke_pkg::KEY_W'($urandom), 1'b1, 13'd1, 13'd8191, 1'b0);
    for (int i = 0; i < 250; i++) begin
      // receiver holds off while pixels keep coming
      if (i == 100) hold_left = 80;
      send_pixel(pick_color(3));
    end
    wait_idle();
  endtask

  // Width saturated to the maximum, zero height: start of one wide row
  task automatic test_wide_row();
    int row_len;
    row_len = 64;
    configure(cke_pkg::KEY_W'($urandom), 1'b1, 13'd8191, 13'd0, 1'b0);
    for (int i = 0; i < row_len; i++) begin
      if (i == row_len - 2) send_pixel(key_reg);
      else if (i == 0 || i >= row_len - 6) send_pixel(off_key());
      else send_pixel(pick_color(40));
    end
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_size_change();
    test_empty_frame();
    test_zero_size();
    test_row_end_runs();
    test_random_frames();
    test_tall_column();
    test_wide_row();
    wait_idle();
    if (predicted_runs.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", predicted_runs.size()));
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
